/* hw/rtl/tar_pkg.sv */
// tar_pkg: shared constants, register indexes, mode codes and beat types
// for the tensor axis reduction unit. No dependencies.
`default_nettype none

package tar_pkg;

    // default sizing, handed down from the top level
    localparam int PARTIAL_DEPTH_DEF = 1024;
    localparam int AXIS_COUNT_DEF    = 4;

    // fixed widths
    localparam int AXES        = 4;
    localparam int AXIS_W      = 2;
    localparam int COORD_W     = 12;
    localparam int EXT_W       = 13;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 48;
    localparam int SLOT_MAX_W  = 16;
    localparam int SCALE_W     = 17;
    localparam int MODE_W      = 3;
    localparam int MASK_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [EXT_W-1:0]   MAX_EXTENT = 13'd4096;
    localparam logic [SCALE_W-1:0] SCALE_ONE  = 17'd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE3 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd6;

    // reduction modes; unused codes fold as sum
    localparam logic [MODE_W-1:0] MODE_MAX  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUM  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MEAN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PROD = 3'd4;

    // front sequencer
    typedef enum logic [0:0] {
        SEQ_SETUP,
        SEQ_RUN
    } seq_state_t;

    // one classified element beat, front to back
    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [SLOT_MAX_W-1:0] slot;
        logic                  first;
        logic                  last;
        logic                  done;
        logic [POS_W-1:0]      position;
    } item_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SCALE_W-1:0] scale;
    } back_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/tar_front.sv */
// tar_front: configuration registers, shape setup sequencer and coordinate
// tracking; classifies each element beat and pushes it to the queue. Uses tar_pkg.
`default_nettype none

module tar_front #(
    parameter int PARTIAL_DEPTH = tar_pkg::PARTIAL_DEPTH_DEF,
    parameter int AXIS_COUNT    = tar_pkg::AXIS_COUNT_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [tar_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [tar_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire                                  elem_valid,
    output logic                                 elem_ready,
    input  wire [tar_pkg::VALUE_W-1:0]           element_value,
    input  wire                                  q_full,
    output logic                                 push,
    output tar_pkg::item_t                       push_item,
    output tar_pkg::back_cfg_t                   back_cfg
);

    localparam int SLOT_W = (PARTIAL_DEPTH > 1) ? $clog2(PARTIAL_DEPTH) : 1;
    localparam int MOD_W  = SLOT_W + 1;
    localparam logic [MOD_W-1:0]  DEPTH_M    = MOD_W'(PARTIAL_DEPTH);
    localparam logic [SLOT_W-1:0] DEPTH_LAST = SLOT_W'(PARTIAL_DEPTH - 1);
    localparam logic [SLOT_W-1:0] ONE_MOD    = (PARTIAL_DEPTH == 1) ? '0 : SLOT_W'(1);
    localparam logic [3:0] BIT_TOP = 4'(tar_pkg::EXT_W - 1);
    localparam logic [tar_pkg::AXIS_W-1:0] AX_TOP = tar_pkg::AXIS_W'(tar_pkg::AXES - 2);

    // configuration registers
    logic [tar_pkg::MODE_W-1:0]  mode_reg;
    logic [tar_pkg::MASK_W-1:0]  mask_reg;
    logic [tar_pkg::COORD_W-1:0] ext_max_reg [tar_pkg::AXES];
    logic [tar_pkg::SCALE_W-1:0] scale_reg;

    // setup sequencer
    tar_pkg::seq_state_t state_reg, state_next;
    logic                        busy;
    logic [tar_pkg::AXIS_W-1:0]  ax_reg;
    logic [tar_pkg::AXIS_W-1:0]  ax_up;
    logic [3:0]                  bit_reg;
    logic [SLOT_W-1:0]           acc_reg;
    logic [SLOT_W-1:0]           m_reg;
    logic [SLOT_W-1:0]           back_reg [tar_pkg::AXES];
    logic [tar_pkg::EXT_W-1:0]   factor;
    logic [MOD_W-1:0]            dbl;
    logic [MOD_W-1:0]            addv;
    logic [SLOT_W-1:0]           step_res;
    logic [SLOT_W-1:0]           step_dec;
    logic                        setup_end;

    // coordinate tracking
    logic [tar_pkg::COORD_W-1:0] coord_reg  [tar_pkg::AXES];
    logic [tar_pkg::COORD_W-1:0] coord_next [tar_pkg::AXES];
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic [tar_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [tar_pkg::AXES-1:0]    at_max;
    logic [tar_pkg::AXES-1:0]    is_zero;
    logic                        first_c, last_c, done_c;
    logic [tar_pkg::AXIS_W-1:0]  inc_ax;
    logic [SLOT_W:0]             diff;
    logic [SLOT_W:0]             diff_wrap;

    logic                        cfg_fire;
    logic                        restart_write;
    logic [tar_pkg::AXIS_W-1:0]  size_ax;

    function automatic logic [tar_pkg::COORD_W-1:0] clamp_max(
        input logic [tar_pkg::EXT_W-1:0] v
    );
        logic [tar_pkg::EXT_W-1:0] c;
        if (v == '0)
            c = tar_pkg::EXT_W'(1);
        else if (v > tar_pkg::MAX_EXTENT)
            c = tar_pkg::MAX_EXTENT;
        else
            c = v;
        return tar_pkg::COORD_W'(c - 1'b1);
    endfunction

    // configuration writes are always taken
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid;
    assign restart_write = cfg_fire && (cfg_index <= tar_pkg::CFG_SIZE3);
    assign size_ax       = tar_pkg::AXIS_W'(cfg_index - tar_pkg::CFG_SIZE0);

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tar_pkg::MODE_SUM;
            mask_reg  <= tar_pkg::MASK_W'(1);
            scale_reg <= tar_pkg::SCALE_ONE;
            for (int k = 0; k < tar_pkg::AXES; k++)
                ext_max_reg[k] <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index) inside
                tar_pkg::CFG_MODE:
                    mode_reg <= cfg_data[tar_pkg::MODE_W-1:0];
                tar_pkg::CFG_MASK:
                    mask_reg <= cfg_data[tar_pkg::MASK_W-1:0];
                tar_pkg::CFG_SIZE0, tar_pkg::CFG_SIZE1,
                tar_pkg::CFG_SIZE2, tar_pkg::CFG_SIZE3:
                begin
                    if (int'(size_ax) < AXIS_COUNT)
                        ext_max_reg[size_ax] <= clamp_max(cfg_data[tar_pkg::EXT_W-1:0]);
                end
                tar_pkg::CFG_SCALE:
                    scale_reg <= (cfg_data > tar_pkg::SCALE_ONE) ? tar_pkg::SCALE_ONE
                                                                 : cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign back_cfg.mode  = mode_reg;
    assign back_cfg.scale = scale_reg;

    // one shift-and-add step of the inner stride product, modulo the store depth
    assign ax_up    = ax_reg + 1'b1;
    assign factor   = mask_reg[ax_up] ? tar_pkg::EXT_W'(1)
                                      : {1'b0, ext_max_reg[ax_up]} + 1'b1;
    assign setup_end = (ax_reg == '0) && (bit_reg == '0);

    always_comb
    begin
        dbl = {acc_reg, 1'b0};
        if (dbl >= DEPTH_M)
            dbl = dbl - DEPTH_M;
        addv = dbl + (factor[bit_reg] ? {1'b0, m_reg} : '0);
        if (addv >= DEPTH_M)
            addv = addv - DEPTH_M;
        step_res = addv[SLOT_W-1:0];
        step_dec = (step_res == '0) ? DEPTH_LAST : step_res - 1'b1;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tar_pkg::SEQ_SETUP:
                if (!restart_write && setup_end)
                    state_next = tar_pkg::SEQ_RUN;
            tar_pkg::SEQ_RUN:
                if (restart_write)
                    state_next = tar_pkg::SEQ_SETUP;
            default:
                state_next = tar_pkg::SEQ_SETUP;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        unique case (state_reg)
            tar_pkg::SEQ_SETUP: busy = 1'b1;
            tar_pkg::SEQ_RUN:   busy = 1'b0;
            default:            busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tar_pkg::SEQ_SETUP;
        else
            state_reg <= state_next;
    end

    // setup datapath: back step of each axis, innermost but one first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg  <= AX_TOP;
            bit_reg <= BIT_TOP;
            acc_reg <= '0;
            m_reg   <= ONE_MOD;
            for (int k = 0; k < tar_pkg::AXES; k++)
                back_reg[k] <= '0;
        end
        else if (restart_write)
        begin
            ax_reg  <= AX_TOP;
            bit_reg <= BIT_TOP;
            acc_reg <= '0;
            m_reg   <= ONE_MOD;
        end
        else if (busy)
        begin
            if (bit_reg == '0)
            begin
                back_reg[ax_reg] <= step_dec;
                m_reg            <= step_res;
                acc_reg          <= '0;
                bit_reg          <= BIT_TOP;
                if (ax_reg != '0)
                    ax_reg <= ax_reg - 1'b1;
            end
            else
            begin
                acc_reg <= step_res;
                bit_reg <= bit_reg - 1'b1;
            end
        end
    end

    // classify the arriving element
    always_comb
    begin
        at_max  = '0;
        is_zero = '0;
        for (int k = 0; k < tar_pkg::AXES; k++)
        begin
            at_max[k]  = (coord_reg[k] == ext_max_reg[k]);
            is_zero[k] = (coord_reg[k] == '0);
        end
    end

    assign first_c = &(is_zero | ~mask_reg);
    assign last_c  = &(at_max | ~mask_reg);
    assign done_c  = &at_max;

    // innermost axis that still has room
    always_comb
    begin
        inc_ax = '0;
        for (int k = 0; k < tar_pkg::AXES; k++)
            if (!at_max[k])
                inc_ax = tar_pkg::AXIS_W'(k);
    end

    // next coordinate, slot and output position
    always_comb
    begin
        for (int k = 0; k < tar_pkg::AXES; k++)
        begin
            if (done_c)
                coord_next[k] = '0;
            else if (tar_pkg::AXIS_W'(k) == inc_ax)
                coord_next[k] = coord_reg[k] + 1'b1;
            else if (tar_pkg::AXIS_W'(k) > inc_ax)
                coord_next[k] = '0;
            else
                coord_next[k] = coord_reg[k];
        end

        diff      = {1'b0, slot_reg} - {1'b0, back_reg[inc_ax]};
        diff_wrap = diff[SLOT_W] ? diff + (SLOT_W+1)'(PARTIAL_DEPTH) : diff;

        if (done_c)
            slot_next = '0;
        else if (mask_reg[inc_ax])
            slot_next = diff_wrap[SLOT_W-1:0];
        else if (slot_reg == DEPTH_LAST)
            slot_next = '0;
        else
            slot_next = slot_reg + 1'b1;

        if (done_c)
            pos_next = '0;
        else if (last_c)
            pos_next = pos_reg + 1'b1;
        else
            pos_next = pos_reg;
    end

    assign elem_ready = !busy && !q_full;
    assign push       = elem_valid && elem_ready;

    assign push_item.value    = element_value;
    assign push_item.slot     = tar_pkg::SLOT_MAX_W'(slot_reg);
    assign push_item.first    = first_c;
    assign push_item.last     = last_c;
    assign push_item.done     = done_c;
    assign push_item.position = pos_reg;

    // tensor position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            pos_reg  <= '0;
            for (int k = 0; k < tar_pkg::AXES; k++)
                coord_reg[k] <= '0;
        end
        else if (restart_write)
        begin
            slot_reg <= '0;
            pos_reg  <= '0;
            for (int k = 0; k < tar_pkg::AXES; k++)
                coord_reg[k] <= '0;
        end
        else if (push)
        begin
            slot_reg <= slot_next;
            pos_reg  <= pos_next;
            for (int k = 0; k < tar_pkg::AXES; k++)
                coord_reg[k] <= coord_next[k];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tar_queue.sv */
// tar_queue: short register queue of classified element beats between the
// front and the back end. Uses tar_pkg.
`default_nettype none

module tar_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  tar_pkg::item_t  push_item,
    output logic            full,
    output logic            head_valid,
    output tar_pkg::item_t  head_item,
    input  wire             pop
);

    localparam int PTR_W = $clog2(tar_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    tar_pkg::item_t   entry_reg [tar_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(tar_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tar_back.sv */
// tar_back: partial store, fold stage with write forwarding, mean scaling
// stage and result register. Uses tar_pkg.
`default_nettype none

module tar_back #(
    parameter int PARTIAL_DEPTH = tar_pkg::PARTIAL_DEPTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              q_valid,
    input  tar_pkg::item_t                   q_item,
    output logic                             q_pop,
    input  tar_pkg::back_cfg_t               cfg,
    output logic                             res_valid,
    input  wire                              res_ready,
    output logic [tar_pkg::VALUE_W-1:0]      reduced_value,
    output logic [tar_pkg::POS_W-1:0]        out_position,
    output logic                             tensor_done,
    output logic                             saturated
);

    localparam int SLOT_W = (PARTIAL_DEPTH > 1) ? $clog2(PARTIAL_DEPTH) : 1;
    localparam int WORD_W = tar_pkg::VALUE_W + 1;

    // partial store: value with its saturation flag on top
    logic [WORD_W-1:0] store_mem [PARTIAL_DEPTH];

    // fold stage
    logic                 s1_valid_reg;
    tar_pkg::item_t       s1_item_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 fwd_valid_reg;
    logic [SLOT_W-1:0]    fwd_slot_reg;
    logic [WORD_W-1:0]    fwd_data_reg;
    logic [SLOT_W-1:0]    s1_slot;
    logic [WORD_W-1:0]    op_word;
    logic signed [31:0]   op;
    logic signed [31:0]   x;
    logic signed [63:0]   prod;
    logic signed [63:0]   prod_rnd;
    logic signed [32:0]   sum33;
    logic signed [63:0]   sum64;
    logic [WORD_W-1:0]    prod_sat;
    logic [WORD_W-1:0]    sum_sat;
    logic signed [31:0]   fold_acc;
    logic                 fold_sat;
    logic                 s1_fire;
    logic                 s1_ready;

    // scaling stage
    logic                 s2_valid_reg;
    logic signed [31:0]   s2_acc_reg;
    logic                 s2_sat_reg;
    logic [tar_pkg::POS_W-1:0] s2_pos_reg;
    logic                 s2_done_reg;
    logic                 s2_ready;
    logic                 s2_fire;
    logic signed [17:0]   scale_s;
    logic signed [63:0]   scaled;
    logic signed [63:0]   scaled_rnd;
    logic [WORD_W-1:0]    mean_sat;
    logic [tar_pkg::VALUE_W-1:0] fin_value;
    logic                 fin_sat;

    logic                 res_valid_reg;
    logic                 out_free;

    // clamp to 32 bits, flag on top
    function automatic logic [WORD_W-1:0] sat_word(input logic signed [63:0] v);
        logic [WORD_W-1:0] r;
        if (v > 64'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -64'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    // handshakes along the back end
    assign out_free = !res_valid_reg || res_ready;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s2_fire  = s2_valid_reg && out_free;
    assign s1_fire  = s1_valid_reg && (!s1_item_reg.last || s2_ready);
    assign s1_ready = !s1_valid_reg || s1_fire;
    assign q_pop    = q_valid && s1_ready;

    // store read on pop, write from the fold stage
    always_ff @(posedge clk)
    begin
        if (s1_fire)
            store_mem[s1_slot] <= {fold_sat, fold_acc};
        if (q_pop)
            rd_data_reg <= store_mem[q_item.slot[SLOT_W-1:0]];
    end

    // fold stage operands; the latest write wins over the read data
    assign s1_slot = s1_item_reg.slot[SLOT_W-1:0];
    assign op_word = (fwd_valid_reg && (fwd_slot_reg == s1_slot)) ? fwd_data_reg
                                                                   : rd_data_reg;
    assign op      = op_word[tar_pkg::VALUE_W-1:0];
    assign x       = s1_item_reg.value;

    // product rounds half up at the Q16.16 point, sum is exact
    assign prod     = op * x;
    assign prod_rnd = (prod + 64'sd32768) >>> 16;
    assign sum33    = {op[31], op} + {x[31], x};
    assign sum64    = {{31{sum33[32]}}, sum33};
    assign prod_sat = sat_word(prod_rnd);
    assign sum_sat  = sat_word(sum64);

    // fold
    always_comb
    begin
        fold_acc = x;
        fold_sat = 1'b0;
        if (!s1_item_reg.first)
        begin
            case (cfg.mode)
                tar_pkg::MODE_MAX:
                begin
                    fold_acc = (x > op) ? x : op;
                    fold_sat = op_word[WORD_W-1];
                end
                tar_pkg::MODE_MIN:
                begin
                    fold_acc = (x < op) ? x : op;
                    fold_sat = op_word[WORD_W-1];
                end
                tar_pkg::MODE_PROD:
                begin
                    fold_acc = prod_sat[tar_pkg::VALUE_W-1:0];
                    fold_sat = op_word[WORD_W-1] | prod_sat[WORD_W-1];
                end
                default:
                begin
                    fold_acc = sum_sat[tar_pkg::VALUE_W-1:0];
                    fold_sat = op_word[WORD_W-1] | sum_sat[WORD_W-1];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            s1_item_reg <= q_item;
        if (s1_fire)
        begin
            fwd_slot_reg <= s1_slot;
            fwd_data_reg <= {fold_sat, fold_acc};
        end
        if (s1_fire && s1_item_reg.last)
        begin
            s2_acc_reg  <= fold_acc;
            s2_sat_reg  <= fold_sat;
            s2_pos_reg  <= s1_item_reg.position;
            s2_done_reg <= s1_item_reg.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
                fwd_valid_reg <= 1'b1;
            if (s1_fire && s1_item_reg.last)
                s2_valid_reg <= 1'b1;
            else if (s2_fire)
                s2_valid_reg <= 1'b0;
        end
    end

    // mean scaling of the finished sum
    assign scale_s    = {1'b0, cfg.scale};
    assign scaled     = s2_acc_reg * scale_s;
    assign scaled_rnd = (scaled + 64'sd32768) >>> 16;
    assign mean_sat   = sat_word(scaled_rnd);

    always_comb
    begin
        if (cfg.mode == tar_pkg::MODE_MEAN)
        begin
            fin_value = mean_sat[tar_pkg::VALUE_W-1:0];
            fin_sat   = s2_sat_reg | mean_sat[WORD_W-1];
        end
        else
        begin
            fin_value = s2_acc_reg;
            fin_sat   = s2_sat_reg;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            reduced_value <= fin_value;
            out_position  <= s2_pos_reg;
            tensor_done   <= s2_done_reg;
            saturated     <= fin_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (s2_fire)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/tensor_axis_reduce_unit.sv */
// Tensor axis reduction unit: max, min, sum, mean and product over chosen axes.
// Throughput: one element per cycle unless setup, a full queue or result
// back-pressure stalls it; the partial store read/write is the loop.
// Reset: coordinates, positions and valids clear; the partial store is not cleared.
// Shape setup runs after reset and after each mode, mask or size write, with
// element ready low; the stride sequencer does one multiplier bit per cycle.
`default_nettype none

module tensor_axis_reduce_unit #(
    parameter int PARTIAL_DEPTH = tar_pkg::PARTIAL_DEPTH_DEF,
    parameter int AXIS_COUNT    = tar_pkg::AXIS_COUNT_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [tar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [tar_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                              elem_valid,
    output logic                             elem_ready,
    input  wire [tar_pkg::VALUE_W-1:0]       element_value,
    output logic                             res_valid,
    input  wire                              res_ready,
    output logic [tar_pkg::VALUE_W-1:0]      reduced_value,
    output logic [tar_pkg::POS_W-1:0]        out_position,
    output logic                             tensor_done,
    output logic                             saturated
);

    logic               push;
    tar_pkg::item_t     push_item;
    logic               q_full;
    logic               q_valid;
    tar_pkg::item_t     q_item;
    logic               q_pop;
    tar_pkg::back_cfg_t back_cfg;

    // front: configuration, setup and classification
    tar_front #(
        .PARTIAL_DEPTH (PARTIAL_DEPTH),
        .AXIS_COUNT    (AXIS_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .elem_valid    (elem_valid),
        .elem_ready    (elem_ready),
        .element_value (element_value),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item),
        .back_cfg      (back_cfg)
    );

    // decoupling queue
    tar_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (q_item),
        .pop        (q_pop)
    );

    // back end: fold, scale, result
    tar_back #(
        .PARTIAL_DEPTH (PARTIAL_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .cfg           (back_cfg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .reduced_value (reduced_value),
        .out_position  (out_position),
        .tensor_done   (tensor_done),
        .saturated     (saturated)
    );

endmodule

`default_nettype wire

/* tb/tensor_axis_reduce_checker.sv */
// Checker for the tensor axis reduction unit: follows the register, element and
// result channels, predicts every result beat and compares it field by field.
// Depends on tar_pkg for widths, register indexes and mode codes.

module tensor_axis_reduce_checker #(
    parameter int PARTIAL_DEPTH = tar_pkg::PARTIAL_DEPTH_DEF,
    parameter int AXIS_COUNT    = tar_pkg::AXIS_COUNT_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_valid,
    input  wire                           cfg_ready,
    input  wire [tar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [tar_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                           elem_valid,
    input  wire                           elem_ready,
    input  wire [tar_pkg::VALUE_W-1:0]    element_value,
    input  wire                           res_valid,
    input  wire                           res_ready,
    input  wire [tar_pkg::VALUE_W-1:0]    reduced_value,
    input  wire [tar_pkg::POS_W-1:0]      out_position,
    input  wire                           tensor_done,
    input  wire                           saturated,
    output int                            error_count,
    output int                            outstanding
);
    import tar_pkg::*;

    // one predicted result beat
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
        logic               done;
        logic               sat;
    } reduction_t;

    reduction_t expected_outputs[$];
    reduction_t oldest;
    int         failures = 0;

    // shadow registers
    logic [MODE_W-1:0]  mode_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [EXT_W-1:0]   size_reg [AXES];
    logic [SCALE_W-1:0] scale_reg;

    // shadow tensor state
    int unsigned        coord [AXES];
    logic [VALUE_W-1:0] partial_value [PARTIAL_DEPTH];
    logic               partial_sat [PARTIAL_DEPTH];
    logic [POS_W-1:0]   emitted;

    // (v + 0.5) >> 16, floor
    function automatic longint round_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic exceeds32(input longint v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // extent as the hardware sees it: zero acts as one, capped at the maximum
    function automatic int unsigned axis_extent(input int k);
        int unsigned s;
        if (k >= AXIS_COUNT)
            return 1;
        s = 32'(size_reg[k]);
        if (s == 0)
            s = 1;
        if (s > 32'(MAX_EXTENT))
            s = 32'(MAX_EXTENT);
        return s;
    endfunction

    task automatic restart_tensor();
        for (int k = 0; k < AXES; k++)
            coord[k] = 0;
        emitted = '0;
    endtask

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MODE:
            begin
                mode_reg = data[MODE_W-1:0];
                restart_tensor();
            end
            CFG_MASK:
            begin
                mask_reg = data[MASK_W-1:0];
                restart_tensor();
            end
            CFG_SIZE0, CFG_SIZE1, CFG_SIZE2, CFG_SIZE3:
            begin
                size_reg[AXIS_W'(idx - CFG_SIZE0)] = data[EXT_W-1:0];
                restart_tensor();
            end
            CFG_SCALE:
                scale_reg = data[SCALE_W-1:0];
            default:
                ;
        endcase
    endtask

    // fold one element into its partial entry, queue a result if it closes one
    task automatic fold_element(input logic [VALUE_W-1:0] raw);
        int unsigned     ext [AXES];
        logic            opens;
        logic            closes;
        logic            whole;
        logic            sat;
        logic            carry;
        longint unsigned flat;
        int              slot;
        longint          x;
        longint          acc;
        longint          r;
        longint          sc;
        reduction_t      res;
        opens  = 1'b1;
        closes = 1'b1;
        whole  = 1'b1;
        flat   = 0;
        for (int k = 0; k < AXES; k++)
        begin
            ext[k] = axis_extent(k);
            if (coord[k] + 1 < ext[k])
                whole = 1'b0;
            if (mask_reg[k])
            begin
                if (coord[k] != 0)
                    opens = 1'b0;
                if (coord[k] + 1 < ext[k])
                    closes = 1'b0;
            end
            else
                flat = flat * ext[k] + coord[k];
        end
        slot = int'(flat % PARTIAL_DEPTH);
        x    = longint'($signed(raw));

        // first contributor loads, the rest fold
        if (opens)
        begin
            acc = x;
            sat = 1'b0;
        end
        else
        begin
            acc = longint'($signed(partial_value[slot]));
            sat = partial_sat[slot];
            case (mode_reg)
                MODE_MAX:
                    if (x > acc)
                        acc = x;
                MODE_MIN:
                    if (x < acc)
                        acc = x;
                MODE_PROD:
                begin
                    r   = round_q16(acc * x);
                    sat = sat | exceeds32(r);
                    acc = clamp32(r);
                end
                default:
                begin
                    r   = acc + x;
                    sat = sat | exceeds32(r);
                    acc = clamp32(r);
                end
            endcase
        end
        partial_value[slot] = acc[VALUE_W-1:0];
        partial_sat[slot]   = sat;

        // last contributor emits, mean scales on the way out
        if (closes)
        begin
            r = acc;
            if (mode_reg == MODE_MEAN)
            begin
                sc  = longint'((scale_reg > SCALE_ONE) ? SCALE_ONE : scale_reg);
                r   = round_q16(acc * sc);
                sat = sat | exceeds32(r);
                r   = clamp32(r);
            end
            res.value    = r[VALUE_W-1:0];
            res.position = emitted;
            res.done     = whole;
            res.sat      = sat;
            expected_outputs = {expected_outputs, res};
            emitted = emitted + 1'b1;
        end

        // raster advance, innermost axis first
        carry = 1'b1;
        for (int k = AXES - 1; k >= 0; k--)
        begin
            if (carry)
            begin
                if (coord[k] + 1 < ext[k])
                begin
                    coord[k] = coord[k] + 1;
                    carry    = 1'b0;
                end
                else
                    coord[k] = 0;
            end
        end
        if (whole)
            restart_tensor();
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  = MODE_SUM;
            mask_reg  = 4'b0001;
            scale_reg = SCALE_ONE;
            for (int k = 0; k < AXES; k++)
                size_reg[k] = 13'd1;
            for (int i = 0; i < PARTIAL_DEPTH; i++)
            begin
                partial_value[i] = '0;
                partial_sat[i]   = 1'b0;
            end
            restart_tensor();
            expected_outputs.delete();
            outstanding <= 0;
            error_count <= failures;
        end
        else
        begin
            // result beat against the oldest prediction
            if (res_valid && res_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected result beat: value %h position %0d done %b sat %b",
                                 reduced_value, out_position, tensor_done, saturated);
                    failures++;
                end
                else
                begin
                    oldest = expected_outputs.pop_front();
                    if (reduced_value !== oldest.value || out_position !== oldest.position ||
                        tensor_done !== oldest.done || saturated !== oldest.sat)
                    begin
                        if (failures < 10)
                        begin
                            $display("result mismatch: expected value %h position %0d done %b sat %b",
                                     oldest.value, oldest.position, oldest.done, oldest.sat);
                            $display("                 actual   value %h position %0d done %b sat %b",
                                     reduced_value, out_position, tensor_done, saturated);
                        end
                        failures++;
                    end
                end
            end
            // register write beat
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            // element beat
            if (elem_valid && elem_ready)
                fold_element(element_value);
            outstanding <= expected_outputs.size();
            error_count <= failures;
        end
    end

endmodule

/* tb/tensor_axis_reduce_unit_tb.sv */
// Top of the tensor axis reduction testbench: clock, reset, register writes,
// element stimulus and result back-pressure, and the final verdict.
// Depends on tar_pkg, tensor_axis_reduce_unit and tensor_axis_reduce_checker.

module tensor_axis_reduce_unit_tb;
    import tar_pkg::*;

    localparam int                    RANDOM_ITEMS = 250;
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE    = 3'd7;
    localparam logic [MODE_W-1:0]     MODE_SPARE   = 3'd7;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  elem_valid    = 1'b0;
    logic [VALUE_W-1:0]    element_value = '0;
    logic                  res_ready     = 1'b0;

    wire                   cfg_ready;
    wire                   elem_ready;
    wire                   res_valid;
    wire [VALUE_W-1:0]     reduced_value;
    wire [POS_W-1:0]       out_position;
    wire                   tensor_done;
    wire                   saturated;

    int error_count;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    tensor_axis_reduce_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .elem_valid    (elem_valid),
        .elem_ready    (elem_ready),
        .element_value (element_value),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .reduced_value (reduced_value),
        .out_position  (out_position),
        .tensor_done   (tensor_done),
        .saturated     (saturated)
    );

    tensor_axis_reduce_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .elem_valid    (elem_valid),
        .elem_ready    (elem_ready),
        .element_value (element_value),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .reduced_value (reduced_value),
        .out_position  (out_position),
        .tensor_done   (tensor_done),
        .saturated     (saturated),
        .error_count   (error_count),
        .outstanding   (outstanding)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result back-pressure
    always @(posedge clk)
        res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // run limit
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // element value mix: extremes, full range and small Q16.16 values
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom;
            default: return 32'($urandom_range(0, 262143)) - 32'd131072;
        endcase
    endfunction

    function automatic int unsigned effective_extent(input int unsigned s);
        if (s == 0)
            return 1;
        if (s > 32'(MAX_EXTENT))
            return 32'(MAX_EXTENT);
        return s;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic send_element(input logic [VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            elem_valid <= 1'b0;
            @(posedge clk);
        end
        elem_valid    <= 1'b1;
        element_value <= value;
        @(posedge clk);
        while (!elem_ready)
            @(posedge clk);
    endtask

    // stop sending, let every predicted beat arrive, then cover the pipeline
    task automatic drain_results();
        elem_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // full register set, written only once the unit is idle
    task automatic program_shape(input logic [MODE_W-1:0] mode,
                                 input logic [MASK_W-1:0] mask,
                                 input int unsigned s0, input int unsigned s1,
                                 input int unsigned s2, input int unsigned s3,
                                 input logic [SCALE_W-1:0] scale);
        drain_results();
        write_register(CFG_MODE, CFG_DATA_W'(mode));
        write_register(CFG_MASK, CFG_DATA_W'(mask));
        write_register(CFG_SIZE0, CFG_DATA_W'(s0[EXT_W-1:0]));
        write_register(CFG_SIZE1, CFG_DATA_W'(s1[EXT_W-1:0]));
        write_register(CFG_SIZE2, CFG_DATA_W'(s2[EXT_W-1:0]));
        write_register(CFG_SIZE3, CFG_DATA_W'(s3[EXT_W-1:0]));
        write_register(CFG_SCALE, scale);
        write_register(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        int unsigned       sizes [AXES];
        int unsigned       beats;
        int                random_items;
        int                tensor_no;
        logic [MODE_W-1:0] mode;
        logic [MASK_W-1:0] mask;
        logic [SCALE_W-1:0] scale;
        logic              truncated;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: every beat is its own finished tensor
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);

        // max and min over extreme values
        program_shape(MODE_MAX, 4'b0001, 2, 1, 1, 1, SCALE_ONE);
        send_element(32'h8000_0000);
        send_element(32'h7fff_ffff);
        program_shape(MODE_MIN, 4'b0001, 2, 1, 1, 1, SCALE_ONE);
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);

        // sum saturating high, then low
        program_shape(MODE_SUM, 4'b0001, 2, 1, 1, 1, SCALE_ONE);
        send_element(32'h7fff_ffff);
        send_element(32'h0000_0001);
        send_element(32'h8000_0000);
        send_element(32'hffff_ffff);

        // mean of a saturated sum, scaled by one half
        program_shape(MODE_MEAN, 4'b0001, 2, 1, 1, 1, 17'd32768);
        send_element(32'h7fff_ffff);
        send_element(32'h7fff_ffff);

        // product saturating, then an exact product at the negative limit
        program_shape(MODE_PROD, 4'b0001, 2, 1, 1, 1, SCALE_ONE);
        send_element(32'h7fff_ffff);
        send_element(32'h7fff_ffff);
        send_element(32'h0001_0000);
        send_element(32'h8000_0000);

        // unused mode code with a zero extent
        program_shape(MODE_SPARE, 4'b0001, 0, 1, 1, 1, 17'h1ffff);
        send_element(32'h4000_0000);
        send_element(32'h4000_0000);

        // no axis reduced, oversized extent, scale above one
        program_shape(MODE_MEAN, 4'b0000, 2, 8191, 1, 1, 17'h1ffff);
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);
        send_element(32'h0001_8000);

        // no axis reduced, zero scale
        program_shape(MODE_MEAN, 4'b0000, 1, 1, 1, 1, 17'd0);
        send_element(32'h7fff_ffff);

        // more live outputs than partial entries: the second pass reads shared slots
        program_shape(MODE_SUM, 4'b0001, 2, 1, 1, PARTIAL_DEPTH_DEF + 1, SCALE_ONE);
        repeat (PARTIAL_DEPTH_DEF + 6) send_element(pick_value());

        // random tensors, idling pattern rotating per tensor
        random_items = 0;
        tensor_no    = 0;
        while ((random_items < RANDOM_ITEMS) || (tensor_no < 4))
        begin
            case (tensor_no % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 49;
                end
                default:
                begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase

            mode      = MODE_W'($urandom_range(0, 7));
            mask      = MASK_W'($urandom_range(0, 15));
            truncated = ($urandom_range(0, 7) == 0);
            beats     = 1;
            for (int k = 0; k < AXES; k++)
            begin
                if (truncated)
                begin
                    case ($urandom_range(0, 3))
                        0:       sizes[k] = 32'(MAX_EXTENT);
                        1:       sizes[k] = $urandom_range(4097, 8191);
                        2:       sizes[k] = $urandom_range(1, 4);
                        default: sizes[k] = 0;
                    endcase
                end
                else if ($urandom_range(0, 15) == 0)
                    sizes[k] = 0;
                else
                    sizes[k] = $urandom_range(1, 4);
                beats = beats * effective_extent(sizes[k]);
            end
            // truncated shapes are sent a short run of beats; the next write restarts them
            if (truncated)
                beats = $urandom_range(3, 24);

            case ($urandom_range(0, 2))
                0:       scale = SCALE_W'($urandom_range(0, 131071));
                1:       scale = SCALE_ONE;
                default: scale = SCALE_W'($urandom_range(0, 65536));
            endcase

            program_shape(mode, mask, sizes[0], sizes[1], sizes[2], sizes[3], scale);
            repeat (beats)
            begin
                send_element(pick_value());
                random_items++;
            end
            tensor_no++;
        end

        drain_results();
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* tensor_axis_reduce_unit.f */
hw/rtl/tar_pkg.sv
hw/rtl/tar_front.sv
hw/rtl/tar_queue.sv
hw/rtl/tar_back.sv
hw/rtl/tensor_axis_reduce_unit.sv
tb/tensor_axis_reduce_checker.sv
tb/tensor_axis_reduce_unit_tb.sv
